FILE: hw/rtl/battery_low_voltage_cutoff_monitor_top_macros.svh
// Assertion helpers for the RTL core (blvc_core).
`ifndef BATTERY_LOW_VOLTAGE_CUTOFF_MONITOR_TOP_MACROS_SVH
`define BATTERY_LOW_VOLTAGE_CUTOFF_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BLVC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define BLVC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/blvc_pkg.sv
package blvc_pkg;

	localparam int MV_W    = 14;
	localparam int CNT_W   = 8;
	localparam int TIME_W  = 48;
	localparam int HOURS_W = 16;
	localparam int HOLD_W  = 38;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;

	localparam logic [HOLD_W-1:0] MS_PER_HOUR = 38'd3600000;
	localparam logic [TIME_W-1:0] MS_PER_DAY  = 48'd86400000;
	localparam logic [CNT_W-1:0]  CNT_MAX     = 8'd255;

	localparam logic [IDX_W-1:0] REG_CUTOFF_MV  = 3'd0;
	localparam logic [IDX_W-1:0] REG_CUTOFF_CNT = 3'd1;
	localparam logic [IDX_W-1:0] REG_NOBAT_MV   = 3'd2;
	localparam logic [IDX_W-1:0] REG_FLOAT_EN   = 3'd3;
	localparam logic [IDX_W-1:0] REG_FLOAT_MV   = 3'd4;
	localparam logic [IDX_W-1:0] REG_FLOAT_HRS  = 3'd5;

	localparam logic [MV_W-1:0]   RST_CUTOFF_MV  = 14'd3100;
	localparam logic [CNT_W-1:0]  RST_CUTOFF_CNT = 8'd10;
	localparam logic [MV_W-1:0]   RST_NOBAT_MV   = 14'd2600;
	localparam logic [MV_W-1:0]   RST_FLOAT_MV   = 14'd4100;
	localparam logic [HOLD_W-1:0] RST_HOLD_MS    = 38'd172800000;

	typedef struct packed {
		logic [MV_W-1:0]   cutoff_mv;
		logic [CNT_W-1:0]  cutoff_cnt;
		logic [MV_W-1:0]   nobat_mv;
		logic              float_en;
		logic [MV_W-1:0]   float_mv;
		logic [HOLD_W-1:0] hold_ms;
	} cfg_t;

endpackage

FILE: hw/rtl/battery_low_voltage_cutoff_monitor_top.sv
// Battery undervoltage monitor. Each input word is one poll (reading_valid,
// millivolts, now_ms); each produces exactly one result word, in order. A poll
// is held in the input register from the accepting edge and moves to the result
// register, raising out_valid, at the next edge where it is free or out_ready
// is high. One word is accepted every cycle while out_ready is high. The
// float-hold threshold in ms is computed when float_warn_hours is written, so
// writes through cfg_we/cfg_index/cfg_data take effect on the next cycle.
// Config indexes: 0 cutoff_millivolts, 1 cutoff_count, 2 no_battery_millivolts,
// 3 float_warn_enable, 4 float_warn_millivolts, 5 float_warn_hours; others
// are ignored. Write config only while no poll is in flight.
module battery_low_voltage_cutoff_monitor_top import blvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              reading_valid,
	input  logic [MV_W-1:0]   millivolts,
	input  logic [TIME_W-1:0] now_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              critical,
	output logic [CNT_W-1:0]  low_count,
	output logic              power_off_request,
	output logic              float_warning,
	output logic              recovered
);

	cfg_t cfg;

	blvc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	blvc_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.reading_valid     (reading_valid),
		.millivolts        (millivolts),
		.now_ms            (now_ms),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.critical          (critical),
		.low_count         (low_count),
		.power_off_request (power_off_request),
		.float_warning     (float_warning),
		.recovered         (recovered)
	);

endmodule

FILE: hw/rtl/blvc_cfg.sv
module blvc_cfg import blvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// hours are kept as a ms threshold so no divide is needed downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cutoff_mv  <= RST_CUTOFF_MV;
			cfg_q.cutoff_cnt <= RST_CUTOFF_CNT;
			cfg_q.nobat_mv   <= RST_NOBAT_MV;
			cfg_q.float_en   <= 1'b0;
			cfg_q.float_mv   <= RST_FLOAT_MV;
			cfg_q.hold_ms    <= RST_HOLD_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CUTOFF_MV:  cfg_q.cutoff_mv  <= cfg_data[MV_W-1:0];
				REG_CUTOFF_CNT: cfg_q.cutoff_cnt <= cfg_data[CNT_W-1:0];
				REG_NOBAT_MV:   cfg_q.nobat_mv   <= cfg_data[MV_W-1:0];
				REG_FLOAT_EN:   cfg_q.float_en   <= cfg_data[0];
				REG_FLOAT_MV:   cfg_q.float_mv   <= cfg_data[MV_W-1:0];
				REG_FLOAT_HRS:  cfg_q.hold_ms    <=
					HOLD_W'(cfg_data[HOURS_W-1:0]) * MS_PER_HOUR;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/blvc_core.sv
`include "battery_low_voltage_cutoff_monitor_top_macros.svh"

module blvc_core import blvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              reading_valid,
	input  logic [MV_W-1:0]   millivolts,
	input  logic [TIME_W-1:0] now_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              critical,
	output logic [CNT_W-1:0]  low_count,
	output logic              power_off_request,
	output logic              float_warning,
	output logic              recovered
);

	logic              valid_s1;
	logic              rv_s1;
	logic [MV_W-1:0]   mv_s1;
	logic [TIME_W-1:0] now_s1;

	logic              out_vq;
	logic              crit_oq, po_oq, warn_oq, rec_oq;
	logic [CNT_W-1:0]  cnt_oq;

	logic [CNT_W-1:0]  cnt_q;
	logic              crit_q;
	logic [TIME_W-1:0] start_q, last_q;

	logic              adv, fire;
	logic              nobat, float_act, below_float;
	logic              start_zero, last_zero, hold_ok, day_ok;
	logic [TIME_W-1:0] diff_start, diff_last;
	logic              warn_n, rec_n, po_n, crit_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [TIME_W-1:0] start_n, last_n;

	assign adv      = !out_vq || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rv_s1  <= reading_valid;
			mv_s1  <= millivolts;
			now_s1 <= now_ms;
		end
	end

	// float-hold check
	always_comb begin
		nobat       = !rv_s1 || (mv_s1 < cfg.nobat_mv);
		float_act   = !nobat && cfg.float_en;
		below_float = mv_s1 < cfg.float_mv;
		start_zero  = start_q == '0;
		last_zero   = last_q == '0;
		diff_start  = now_s1 - start_q;
		diff_last   = now_s1 - last_q;
		hold_ok     = (cfg.hold_ms == '0) ||
			((now_s1 >= start_q) && (diff_start >= TIME_W'(cfg.hold_ms)));
		day_ok      = last_zero || ((now_s1 >= last_q) && (diff_last >= MS_PER_DAY));
		warn_n      = float_act && !below_float && !start_zero && hold_ok && day_ok;
		start_n     = start_q;
		last_n      = last_q;
		if (float_act) begin
			if (below_float) begin
				start_n = '0;
				last_n  = '0;
			end else if (start_zero) begin
				start_n = now_s1;
			end else if (warn_n) begin
				last_n = now_s1;
			end
		end
	end

	// low-voltage counter
	always_comb begin
		rec_n  = 1'b0;
		po_n   = 1'b0;
		crit_n = 1'b0;
		cnt_n  = '0;
		if (!nobat) begin
			if (mv_s1 >= cfg.cutoff_mv) begin
				rec_n = cnt_q != '0;
			end else begin
				crit_n = 1'b1;
				cnt_n  = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
				po_n   = cnt_n >= cfg.cutoff_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			crit_q  <= 1'b0;
			start_q <= '0;
			last_q  <= '0;
			out_vq  <= 1'b0;
		end else begin
			if (adv) begin
				out_vq <= valid_s1;
			end
			if (fire) begin
				cnt_q   <= cnt_n;
				crit_q  <= crit_n;
				start_q <= start_n;
				last_q  <= last_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			crit_oq <= crit_n;
			cnt_oq  <= cnt_n;
			po_oq   <= po_n;
			warn_oq <= warn_n;
			rec_oq  <= rec_n;
		end
	end

	assign out_valid         = out_vq;
	assign critical          = crit_oq;
	assign low_count         = cnt_oq;
	assign power_off_request = po_oq;
	assign float_warning     = warn_oq;
	assign recovered         = rec_oq;

	`BLVC_ASSERT_IMP(a_out_tracks_state, out_vq, (cnt_oq == cnt_q) && (crit_oq == crit_q), "result word disagrees with state")
	`BLVC_ASSERT_IMP(a_crit_has_count, crit_q, cnt_q != '0, "critical with zero low count")
	`BLVC_ASSERT_IMP(a_po_is_low, out_vq && po_oq, crit_oq && !rec_oq, "power-off on a non-low word")
	`BLVC_ASSERT_NXT(a_warn_marks_time, fire && warn_n, last_q == $past(now_s1), "warning time not recorded")

endmodule
